/* design/des_pkg.sv */
// ----------------------------------------------------------------------------
// des_pkg
// DES tables, permutation helpers and shared types
// ----------------------------------------------------------------------------
`default_nettype none
package des_pkg;

    localparam int unsigned RoundCount = 16;
    localparam int unsigned PaddrWidth = 4;
    localparam logic [PaddrWidth-1:0] AddrCipherKey = 4'h0;
    localparam int unsigned QueueDepthDefault = 2;

    typedef logic [47:0] t_round_key;

    typedef struct packed {
        logic        func;
        logic [63:0] blk;
    } t_job;

    localparam logic [7:0] IP_TAB [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam logic [7:0] FP_TAB [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam logic [7:0] E_TAB [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam logic [7:0] P_TAB [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam logic [7:0] PC1_TAB [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,19,11,3,60,52,44,36,
        63,55,47,39,31,23,15,7,62,54,46,38,30,22,
        14,6,61,53,45,37,29,21,13,5,28,20,12,4};
    localparam logic [7:0] PC2_TAB [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,
        26,8,16,7,27,20,13,2,41,52,31,37,47,55,30,40,
        51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [1:0] ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] k);
        return (k == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] h, input t_round_key rk);
        logic [47:0] x;
        logic [31:0] s;
        logic [5:0]  b;
        logic [31:0] r;
        for (int i = 0; i < 48; i++) x[47-i] = h[32-int'(E_TAB[i])];
        x = x ^ rk;
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX_TAB[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) r[31-i] = s[32-int'(P_TAB[i])];
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/des_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// des_block_cipher_top
// DES ECB engine, one 64-bit word per cycle
// ----------------------------------------------------------------------------
// A word is accepted whenever i_valid is high and o_stall low; results come out
// in order through the queue, input register, sixteen round stages and output
// register, one per cycle sustained, set by the fully unrolled sixteen-round
// pipeline. The round pipeline freezes while i_stall holds a waiting result.
// Write cipher_key at address 0 only when no word is in flight.
`default_nettype none
module des_block_cipher_top #(
    parameter int unsigned QUEUE_DEPTH = des_pkg::QueueDepthDefault
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [des_pkg::PaddrWidth-1:0] paddr,
    input  wire  [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_func,
    input  wire  [63:0]                    i_data_block,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [63:0]                    o_result_block
);
    import des_pkg::*;

    t_round_key rks [RoundCount];
    t_job       in_job;
    t_job       q_job;
    logic       q_valid;
    logic       q_take;

    assign in_job = '{func: i_func, blk: i_data_block};

    des_key_sched u_keys (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_round_keys(rks)
    );

    des_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_job(in_job),
        .o_valid(q_valid), .i_take(q_take), .o_job(q_job)
    );

    des_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_take(q_take), .i_job(q_job),
        .i_round_keys(rks), .o_valid, .i_stall, .o_result_block
    );

endmodule
`default_nettype wire

/* design/des_key_sched.sv */
// ----------------------------------------------------------------------------
// des_key_sched
// key register, apb write/read and the sixteen round keys derived from it
// ----------------------------------------------------------------------------
`default_nettype none
module des_key_sched (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [des_pkg::PaddrWidth-1:0]     paddr,
    input  wire  [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    output des_pkg::t_round_key                o_round_keys [des_pkg::RoundCount]
);
    import des_pkg::*;

    logic [63:0] r_key;
    logic [63:0] n_key;
    logic        wr_en;
    logic [55:0] pc1_key;
    logic [27:0] c_half [RoundCount+1];
    logic [27:0] d_half [RoundCount+1];

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == AddrCipherKey);
    assign n_key  = wr_en ? pwdata : r_key;
    assign prdata = (paddr == AddrCipherKey) ? r_key : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 64'd0;
        end else begin
            r_key <= n_key;
        end
    end

    // round keys follow the key register combinationally, fixed between writes
    assign pc1_key   = perm_pc1(r_key);
    assign c_half[0] = pc1_key[55:28];
    assign d_half[0] = pc1_key[27:0];

    for (genvar g = 0; g < RoundCount; g++) begin : g_rk
        assign c_half[g+1]     = rot28(c_half[g], ROT_TAB[g]);
        assign d_half[g+1]     = rot28(d_half[g], ROT_TAB[g]);
        assign o_round_keys[g] = perm_pc2({c_half[g+1], d_half[g+1]});
    end

endmodule
`default_nettype wire

/* design/des_front.sv */
// ----------------------------------------------------------------------------
// des_front
// input skid queue; decouples input handshake from the round pipeline
// ----------------------------------------------------------------------------
`default_nettype none
module des_front #(
    parameter int unsigned DEPTH = des_pkg::QueueDepthDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  des_pkg::t_job       i_job,
    output logic                o_valid,
    input  wire                 i_take,
    output des_pkg::t_job       o_job
);
    import des_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job             r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             push;
    logic             pop;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_take;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH)) |-> o_stall) else $error("full queue not stalling");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("count step");

endmodule
`default_nettype wire

/* design/des_back.sv */
// ----------------------------------------------------------------------------
// des_back
// input register, sixteen-stage round pipeline and output register, stalls as a whole
// ----------------------------------------------------------------------------
`default_nettype none
module des_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_take,
    input  des_pkg::t_job       i_job,
    input  des_pkg::t_round_key i_round_keys [des_pkg::RoundCount],
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [63:0]         o_result_block
);
    import des_pkg::*;

    logic        r_vld [RoundCount+1];
    logic        r_fn  [RoundCount+1];
    logic [31:0] r_l   [RoundCount+1];
    logic [31:0] r_r   [RoundCount+1];
    logic [63:0] r_out;
    logic        r_out_vld;
    logic        adv;
    logic [63:0] ip_blk;

    // pipeline advances when the output slot is free or being taken
    assign adv    = !r_out_vld || !i_stall;
    assign o_take = adv;
    assign ip_blk = perm_ip(i_job.blk);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fn[0] <= i_job.func;
            r_l[0]  <= ip_blk[63:32];
            r_r[0]  <= ip_blk[31:0];
            for (int s = 0; s < RoundCount; s++) begin
                r_fn[s+1] <= r_fn[s];
                r_l[s+1]  <= r_r[s];
                r_r[s+1]  <= r_l[s] ^ feistel(r_r[s],
                    r_fn[s] ? i_round_keys[RoundCount-1-s] : i_round_keys[s]);
            end
            r_out <= perm_fp({r_r[RoundCount], r_l[RoundCount]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= RoundCount; s++) r_vld[s] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 0; s < RoundCount; s++) r_vld[s+1] <= r_vld[s];
            r_out_vld <= r_vld[RoundCount];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_block = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_out_vld && $stable(r_out))) else $error("lost result");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !o_take) else $error("take while blocked");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[RoundCount]) |=> r_out_vld) else $error("result dropped");

endmodule
`default_nettype wire
